// ===== design/rtum_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtum_pkg: shared types and constants of the timestamp parser
// character codes, field limits, calendar tables and the unit's op bundle
// ----------------------------------------------------------------------------
package rtum_pkg;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_DASH    = 8'h2d;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_COLON   = 8'h3a;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_UPPER_T = 8'h54;
  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;

  localparam logic [4:0] FIXED_LEN   = 5'd19;
  localparam logic [1:0] FRAC_DIGITS = 2'd3;
  localparam logic [2:0] ZONE_LEN    = 3'd5;
  localparam logic [6:0] MAX_HOUR    = 7'd23;
  localparam logic [6:0] MAX_MINUTE  = 7'd59;
  localparam logic [6:0] MIN_PER_HR  = 7'd60;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned FIELD_W = 7;
  localparam int unsigned FRAC_W  = 10;
  localparam int unsigned ZONE_W  = 12;
  localparam int unsigned MS_W    = 49;
  localparam int unsigned K_W     = 13;

  // reciprocal of 100 scaled by 2^19, exact for values below 43690
  localparam logic [K_W-1:0] K_RECIP100  = 13'd5243;
  localparam int unsigned    RECIP_SHIFT = 19;
  localparam logic [K_W-1:0] K_DAYS_YEAR = 13'd365;
  localparam logic [K_W-1:0] K_HOURS     = 13'd24;
  localparam logic [K_W-1:0] K_SIXTY     = 13'd60;
  localparam logic [K_W-1:0] K_MILLI     = 13'd1000;

  localparam logic [YEAR_W-1:0] YEAR_SHIFT = 14'd400;
  // days from the shifted civil origin to 1970-01-01, plus one for the day base
  localparam logic signed [20:0] DAY_BASE = -21'sd865566;

  typedef struct packed {
    logic                     pre_ok;
    logic [YEAR_W-1:0]        year;
    logic [FIELD_W-1:0]       month;
    logic [FIELD_W-1:0]       day;
    logic [FIELD_W-1:0]       hour;
    logic [FIELD_W-1:0]       minute;
    logic [FIELD_W-1:0]       second;
    logic [FRAC_W-1:0]        frac_ms;
    logic signed [ZONE_W-1:0] zone_min;
  } rtum_fields_t;

  typedef struct packed {
    logic                   en;
    logic signed [MS_W-1:0] mul_a;
    logic [K_W-1:0]         mul_k;
    logic signed [MS_W-1:0] add_b;
  } rtum_mac_op_t;

  function automatic logic [4:0] month_days(input logic [FIELD_W-1:0] month,
                                            input logic leap);
    logic [4:0] days;
    case (month)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: days = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    days = 5'd30;
      7'd2:                                       days = leap ? 5'd29 : 5'd28;
      default:                                    days = 5'd0;
    endcase
    return days;
  endfunction

  // first day of a month in a march-based year
  function automatic logic [8:0] doy_start(input logic [FIELD_W-1:0] mp);
    logic [8:0] doy;
    case (mp)
      7'd0:    doy = 9'd0;
      7'd1:    doy = 9'd31;
      7'd2:    doy = 9'd61;
      7'd3:    doy = 9'd92;
      7'd4:    doy = 9'd122;
      7'd5:    doy = 9'd153;
      7'd6:    doy = 9'd184;
      7'd7:    doy = 9'd214;
      7'd8:    doy = 9'd245;
      7'd9:    doy = 9'd275;
      7'd10:   doy = 9'd306;
      7'd11:   doy = 9'd337;
      default: doy = 9'd0;
    endcase
    return doy;
  endfunction

endpackage
`default_nettype wire

// ===== design/rtum_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtum_mac: shared multiply-add unit
// acc <= a * k + b, one request per cycle, result held in its register
// ----------------------------------------------------------------------------
module rtum_mac (
  input  wire                             clk_i,
  input  rtum_pkg::rtum_mac_op_t          op_i,
  output logic signed [rtum_pkg::MS_W-1:0] acc_o
);
  import rtum_pkg::*;

  logic signed [MS_W+K_W:0] prod;
  logic signed [MS_W-1:0]   acc_d;
  logic signed [MS_W-1:0]   acc_q;

  always_comb begin
    prod  = op_i.mul_a * $signed({1'b0, op_i.mul_k});
    acc_d = MS_W'(prod[MS_W-1:0] + op_i.add_b);
  end

  always_ff @(posedge clk_i) begin
    if (op_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule
`default_nettype wire

// ===== design/rtum_lexer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtum_lexer: character scanner
// checks the timestamp layout one character a cycle while take_i is high and collects the fields
// ----------------------------------------------------------------------------
module rtum_lexer (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    take_i,
  input  wire  [7:0]             text_char_i,
  input  wire                    is_final_i,
  output logic                   done_o,
  output rtum_pkg::rtum_fields_t fields_o
);
  import rtum_pkg::*;

  typedef enum logic [2:0] {
    PH_FIXED,
    PH_AFTER_SEC,
    PH_FRAC_FIRST,
    PH_FRAC_MORE,
    PH_ZULU,
    PH_ZONE,
    PH_ZONE_DONE
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [4:0]          char_idx_q, char_idx_d;
  logic [YEAR_W-1:0]   year_q, year_d;
  logic [FIELD_W-1:0]  month_q, month_d, day_q, day_d;
  logic [FIELD_W-1:0]  hour_q, hour_d, minute_q, minute_d, second_q, second_d;
  logic [FRAC_W-1:0]   frac_q, frac_d;
  logic [1:0]          frac_cnt_q, frac_cnt_d;
  logic                zone_neg_q, zone_neg_d;
  logic [FIELD_W-1:0]  zone_hour_q, zone_hour_d, zone_minute_q, zone_minute_d;
  logic [2:0]          zone_idx_q, zone_idx_d;
  logic                malformed_q, malformed_d;
  logic                done_q, done_d;

  logic [3:0]          dig;
  logic                is_dig;
  logic                is_zulu;
  logic                is_sign;
  logic [FRAC_W-1:0]   frac_add;
  logic                zone_on;
  logic [12:0]         zone_total;
  logic [ZONE_W-1:0]   zone_mag;

  function automatic logic [FIELD_W-1:0] acc7(input logic [FIELD_W-1:0] acc,
                                              input logic [3:0] d);
    return FIELD_W'(acc * 7'd10 + {3'd0, d});
  endfunction

  always_comb begin
    // low nibble of '0'..'9' is the digit value
    dig     = text_char_i[3:0];
    is_dig  = (text_char_i >= CH_ZERO) && (text_char_i <= CH_NINE);
    is_zulu = text_char_i inside {CH_UPPER_Z, CH_LOWER_Z};
    is_sign = text_char_i inside {CH_PLUS, CH_DASH};

    case (frac_cnt_q)
      2'd0:    frac_add = {6'd0, dig} * 10'd100;
      2'd1:    frac_add = {6'd0, dig} * 10'd10;
      default: frac_add = {6'd0, dig};
    endcase

    phase_d       = phase_q;
    char_idx_d    = char_idx_q;
    year_d        = year_q;
    month_d       = month_q;
    day_d         = day_q;
    hour_d        = hour_q;
    minute_d      = minute_q;
    second_d      = second_q;
    frac_d        = frac_q;
    frac_cnt_d    = frac_cnt_q;
    zone_neg_d    = zone_neg_q;
    zone_hour_d   = zone_hour_q;
    zone_minute_d = zone_minute_q;
    zone_idx_d    = zone_idx_q;
    malformed_d   = malformed_q;
    done_d        = 1'b0;

    if (done_q) begin
      phase_d       = PH_FIXED;
      char_idx_d    = '0;
      year_d        = '0;
      month_d       = '0;
      day_d         = '0;
      hour_d        = '0;
      minute_d      = '0;
      second_d      = '0;
      frac_d        = '0;
      frac_cnt_d    = '0;
      zone_neg_d    = 1'b0;
      zone_hour_d   = '0;
      zone_minute_d = '0;
      zone_idx_d    = '0;
      malformed_d   = 1'b0;
    end else if (take_i) begin
      done_d = is_final_i;
      if (!malformed_q) begin
        case (phase_q)
          PH_FIXED: begin
            if (char_idx_q == 5'd4 || char_idx_q == 5'd7) begin
              if (text_char_i != CH_DASH) malformed_d = 1'b1;
            end else if (char_idx_q == 5'd10) begin
              if (!(text_char_i inside {CH_UPPER_T, CH_LOWER_T})) malformed_d = 1'b1;
            end else if (char_idx_q == 5'd13 || char_idx_q == 5'd16) begin
              if (text_char_i != CH_COLON) malformed_d = 1'b1;
            end else if (!is_dig) begin
              malformed_d = 1'b1;
            end else if (char_idx_q <= 5'd3) begin
              year_d = YEAR_W'(year_q * 14'd10 + {10'd0, dig});
            end else if (char_idx_q <= 5'd6) begin
              month_d = acc7(month_q, dig);
            end else if (char_idx_q <= 5'd9) begin
              day_d = acc7(day_q, dig);
            end else if (char_idx_q <= 5'd12) begin
              hour_d = acc7(hour_q, dig);
            end else if (char_idx_q <= 5'd15) begin
              minute_d = acc7(minute_q, dig);
            end else begin
              second_d = acc7(second_q, dig);
            end
            char_idx_d = char_idx_q + 5'd1;
            if (char_idx_d == FIXED_LEN) phase_d = PH_AFTER_SEC;
          end
          PH_AFTER_SEC: begin
            if (text_char_i == CH_DOT) begin
              phase_d = PH_FRAC_FIRST;
            end else if (is_zulu) begin
              phase_d = PH_ZULU;
            end else if (is_sign) begin
              zone_neg_d = (text_char_i == CH_DASH);
              zone_idx_d = '0;
              phase_d    = PH_ZONE;
            end else begin
              malformed_d = 1'b1;
            end
          end
          PH_FRAC_FIRST, PH_FRAC_MORE: begin
            if (is_dig) begin
              if (frac_cnt_q < FRAC_DIGITS) begin
                frac_d     = frac_q + frac_add;
                frac_cnt_d = frac_cnt_q + 2'd1;
              end
              phase_d = PH_FRAC_MORE;
            end else if (phase_q == PH_FRAC_MORE && is_zulu) begin
              phase_d = PH_ZULU;
            end else if (phase_q == PH_FRAC_MORE && is_sign) begin
              zone_neg_d = (text_char_i == CH_DASH);
              zone_idx_d = '0;
              phase_d    = PH_ZONE;
            end else begin
              malformed_d = 1'b1;
            end
          end
          PH_ZONE: begin
            if (zone_idx_q == 3'd2) begin
              if (text_char_i != CH_COLON) malformed_d = 1'b1;
            end else if (!is_dig) begin
              malformed_d = 1'b1;
            end else if (zone_idx_q < 3'd2) begin
              zone_hour_d = acc7(zone_hour_q, dig);
            end else begin
              zone_minute_d = acc7(zone_minute_q, dig);
            end
            zone_idx_d = zone_idx_q + 3'd1;
            if (zone_idx_d >= ZONE_LEN) phase_d = PH_ZONE_DONE;
          end
          default: begin
            malformed_d = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_FIXED;
      char_idx_q    <= '0;
      year_q        <= '0;
      month_q       <= '0;
      day_q         <= '0;
      hour_q        <= '0;
      minute_q      <= '0;
      second_q      <= '0;
      frac_q        <= '0;
      frac_cnt_q    <= '0;
      zone_neg_q    <= 1'b0;
      zone_hour_q   <= '0;
      zone_minute_q <= '0;
      zone_idx_q    <= '0;
      malformed_q   <= 1'b0;
      done_q        <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      char_idx_q    <= char_idx_d;
      year_q        <= year_d;
      month_q       <= month_d;
      day_q         <= day_d;
      hour_q        <= hour_d;
      minute_q      <= minute_d;
      second_q      <= second_d;
      frac_q        <= frac_d;
      frac_cnt_q    <= frac_cnt_d;
      zone_neg_q    <= zone_neg_d;
      zone_hour_q   <= zone_hour_d;
      zone_minute_q <= zone_minute_d;
      zone_idx_q    <= zone_idx_d;
      malformed_q   <= malformed_d;
      done_q        <= done_d;
    end
  end

  // snapshot of the finished string
  always_comb begin
    zone_on    = (phase_q == PH_ZONE_DONE);
    zone_total = {6'd0, zone_hour_q} * {6'd0, MIN_PER_HR} + {6'd0, zone_minute_q};
    zone_mag   = ZONE_W'(zone_total);

    fields_o.pre_ok = !malformed_q && (phase_q == PH_ZULU || zone_on)
                      && hour_q <= MAX_HOUR && minute_q <= MAX_MINUTE
                      && second_q <= MAX_MINUTE && day_q != '0
                      && (!zone_on || (zone_hour_q <= MAX_HOUR
                                       && zone_minute_q <= MAX_MINUTE));
    fields_o.year    = year_q;
    fields_o.month   = month_q;
    fields_o.day     = day_q;
    fields_o.hour    = hour_q;
    fields_o.minute  = minute_q;
    fields_o.second  = second_q;
    fields_o.frac_ms = frac_q;
    if (!zone_on) begin
      fields_o.zone_min = '0;
    end else if (zone_neg_q) begin
      fields_o.zone_min = $signed(-zone_mag);
    end else begin
      fields_o.zone_min = $signed(zone_mag);
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

// ===== design/rtum_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtum_seq: epoch sequencer
// checks the calendar date and folds the fields into milliseconds on the unit
// ----------------------------------------------------------------------------
module rtum_seq (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              load_i,
  input  rtum_pkg::rtum_fields_t           fields_i,
  output rtum_pkg::rtum_mac_op_t           op_o,
  input  wire signed [rtum_pkg::MS_W-1:0]  acc_i,
  output logic                             busy_o,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic                             ok_o,
  output logic signed [rtum_pkg::MS_W-1:0] epoch_ms_o
);
  import rtum_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEAP,
    S_Q100,
    S_DAYS,
    S_HOUR,
    S_MIN,
    S_SEC,
    S_MS,
    S_OUT
  } state_e;

  state_e              state_q;
  rtum_fields_t        f_q;
  logic [YEAR_W-1:0]   y_adj_q;
  logic signed [20:0]  base_q;
  logic                ok_q;
  logic                out_valid_q;

  logic [FIELD_W-1:0]  q_cur;
  logic [YEAR_W-1:0]   rem100;
  logic                leap;
  logic [4:0]          dim;
  logic                day_ok;
  logic [FIELD_W-1:0]  mp;
  logic [8:0]          doy;
  logic signed [20:0]  base_d;
  logic signed [7:0]   adj;
  logic signed [12:0]  min_zone;
  logic [YEAR_W-1:0]   y_adj_d;

  always_comb begin
    q_cur  = acc_i[RECIP_SHIFT+FIELD_W-1:RECIP_SHIFT];
    rem100 = YEAR_W'(f_q.year - {7'd0, q_cur} * 14'd100);
    leap   = (rem100 == '0) ? (q_cur[1:0] == 2'd0) : (f_q.year[1:0] == 2'd0);
    dim    = month_days(f_q.month, leap);
    day_ok = f_q.day <= {2'd0, dim};
    mp     = (f_q.month > 7'd2) ? FIELD_W'(f_q.month - 7'd3) : FIELD_W'(f_q.month + 7'd9);
    doy    = doy_start(mp);
    base_d = $signed({9'd0, y_adj_q[YEAR_W-1:2]}) + $signed({12'd0, doy})
             + $signed({14'd0, f_q.day}) + DAY_BASE;
    adj    = $signed({3'd0, q_cur[FIELD_W-1:2]}) - $signed({1'b0, q_cur});
    min_zone = $signed({6'd0, f_q.minute}) - $signed({f_q.zone_min[ZONE_W-1], f_q.zone_min});
    y_adj_d  = YEAR_W'(fields_i.year + YEAR_SHIFT
                       - ((fields_i.month <= 7'd2) ? 14'd1 : 14'd0));

    op_o.en    = 1'b1;
    op_o.mul_a = acc_i;
    op_o.mul_k = K_SIXTY;
    op_o.add_b = '0;
    case (state_q)
      S_LEAP: begin
        op_o.mul_a = $signed({35'd0, f_q.year});
        op_o.mul_k = K_RECIP100;
      end
      S_Q100: begin
        op_o.mul_a = $signed({35'd0, y_adj_q});
        op_o.mul_k = K_RECIP100;
      end
      S_DAYS: begin
        op_o.mul_a = $signed({35'd0, y_adj_q});
        op_o.mul_k = K_DAYS_YEAR;
        op_o.add_b = $signed({{28{base_q[20]}}, base_q}) + $signed({{41{adj[7]}}, adj});
      end
      S_HOUR: begin
        op_o.mul_k = K_HOURS;
        op_o.add_b = $signed({42'd0, f_q.hour});
      end
      S_MIN: begin
        op_o.add_b = $signed({{36{min_zone[12]}}, min_zone});
      end
      S_SEC: begin
        op_o.add_b = $signed({42'd0, f_q.second});
      end
      S_MS: begin
        op_o.mul_k = K_MILLI;
        op_o.add_b = $signed({39'd0, f_q.frac_ms});
      end
      default: begin
        op_o.en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      f_q         <= '0;
      y_adj_q     <= '0;
      base_q      <= '0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (load_i) begin
            f_q     <= fields_i;
            y_adj_q <= y_adj_d;
            state_q <= S_LEAP;
          end
        end
        S_LEAP: begin
          base_q  <= base_d;
          state_q <= S_Q100;
        end
        S_Q100: begin
          ok_q    <= f_q.pre_ok && day_ok;
          state_q <= S_DAYS;
        end
        S_DAYS: state_q <= S_HOUR;
        S_HOUR: state_q <= S_MIN;
        S_MIN:  state_q <= S_SEC;
        S_SEC:  state_q <= S_MS;
        S_MS: begin
          out_valid_q <= 1'b1;
          state_q     <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign epoch_ms_o  = ok_q ? acc_i : '0;

endmodule
`default_nettype wire

// ===== design/rfc3339_to_unix_ms_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfc3339_to_unix_ms_parser: timestamp text to signed unix milliseconds
// scans one character per request and converts the date on a shared unit
// ----------------------------------------------------------------------------
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   text_char_i, is_final_i
//   out      output     out_valid_o / out_stall_i ok_o, epoch_ms_o
//
// a non-final character is taken without stalling the input
// the final character hands the fields to the sequencer, which then runs seven
// steps of the shared multiply-add unit before the result is valid
// in_stall_o stays high from the final character until the result is taken
// reset clears the scanner and sequencer at once, no clearing pass
// ----------------------------------------------------------------------------
module rfc3339_to_unix_ms_parser (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [7:0]                       text_char_i,
  input  wire                              is_final_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic                             ok_o,
  output logic signed [rtum_pkg::MS_W-1:0] epoch_ms_o
);
  import rtum_pkg::*;

  logic                   take;
  logic                   done;
  logic                   busy;
  rtum_fields_t           fields;
  rtum_mac_op_t           mac_op;
  logic signed [MS_W-1:0] acc;

  assign in_stall_o = done || busy;
  assign take       = in_valid_i && !in_stall_o;

  rtum_lexer u_lexer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .text_char_i (text_char_i),
    .is_final_i  (is_final_i),
    .done_o      (done),
    .fields_o    (fields)
  );

  rtum_mac u_mac (
    .clk_i (clk_i),
    .op_i  (mac_op),
    .acc_o (acc)
  );

  rtum_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (done),
    .fields_i    (fields),
    .op_o        (mac_op),
    .acc_i       (acc),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ok_o        (ok_o),
    .epoch_ms_o  (epoch_ms_o)
  );

endmodule
`default_nettype wire
